@@ sv/averaged_load_cell_weight_defines.svh @@
// Assertion macros shared by the averaged load cell weight RTL.
`ifndef AVERAGED_LOAD_CELL_WEIGHT_DEFINES_SVH
`define AVERAGED_LOAD_CELL_WEIGHT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ALCW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ALCW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/alcw_pkg.sv @@
// Shared constants, register codes and types of the averaged load cell weight block.
package alcw_pkg;

   // Sample and accumulator widths.
   localparam int SAMPLE_BITS = 12;
   localparam int COUNT_BITS  = 10;
   localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
   localparam int FULL_SCALE  = (1 << SAMPLE_BITS) - 1;

   // Field widths of registers and results.
   localparam int MEAN_BITS   = 12;
   localparam int REF_BITS    = 23;
   localparam int OFFSET_BITS = 24;
   localparam int SLOPE_BITS  = 20;
   localparam int GRAMS_BITS  = 21;
   localparam int UV_BITS     = 23;

   localparam int DEFAULT_REF_UV = 3300000;
   localparam int GRAMS_SCALE    = 1000;
   localparam int SCALE_BITS     = 10;

   // Difference of microvolts and offset, signed.
   localparam int DIFF_W = OFFSET_BITS + 1;

   // Serial multiplier: A is shifted out one bit per cycle.
   localparam int MUL_A_W = (SAMPLE_BITS > SCALE_BITS) ? SAMPLE_BITS : SCALE_BITS;
   localparam int MUL_B_W = DIFF_W;
   localparam int PROD_W  = (SAMPLE_BITS + REF_BITS > DIFF_W + SCALE_BITS) ?
                            (SAMPLE_BITS + REF_BITS) : (DIFF_W + SCALE_BITS);
   localparam int MUL_STEP_W = $clog2(MUL_A_W + 1);

   // Serial divider: one quotient bit per cycle.
   localparam int DIV_W      = PROD_W;
   localparam int DVS_W      = REF_BITS;
   localparam int DIV_STEP_W = $clog2(DIV_W + 1);

   // Signed quotient of the weight division.
   localparam int GQ_W = DIV_W + 1;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLES_PER_RESULT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_REFERENCE_UV       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET_UV          = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SLOPE              = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_GRAMS          = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_GRAMS          = 3'd5;

   // Result status codes.
   localparam logic STATUS_OK         = 1'b0;
   localparam logic STATUS_READ_ERROR = 1'b1;

   // Status of a serial arithmetic unit.
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

@@ sv/alcw_serial_mul.sv @@
// Shift-and-add multiplier that consumes one multiplier bit per cycle.
module alcw_serial_mul (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [alcw_pkg::MUL_A_W-1:0]    op_a,
   input  logic [alcw_pkg::MUL_B_W-1:0]    op_b,
   output alcw_pkg::unit_status_type       status,
   output logic [alcw_pkg::PROD_W-1:0]     product
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [alcw_pkg::MUL_STEP_W-1:0]   step_ff, step_in;
   logic [alcw_pkg::MUL_A_W-1:0]      a_ff, a_in;
   logic [alcw_pkg::PROD_W-1:0]       b_ff, b_in;
   logic [alcw_pkg::PROD_W-1:0]       acc_ff, acc_in;

   // Sequencing: load on start, then one bit of A per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         a_in    = op_a;
         b_in    = alcw_pkg::PROD_W'(op_b);
         acc_in  = '0;
      end else if (busy_ff) begin
         if (a_ff[0]) begin
            acc_in = acc_ff + b_ff;
         end
         a_in    = a_ff >> 1;
         b_in    = b_ff << 1;
         step_in = step_ff + 1'b1;
         if (step_ff == alcw_pkg::MUL_STEP_W'(alcw_pkg::MUL_A_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Operand and accumulator shift registers.
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = acc_ff;

endmodule

@@ sv/alcw_serial_div.sv @@
// Restoring divider that produces one quotient bit per cycle, shared by all divisions.
module alcw_serial_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [alcw_pkg::DIV_W-1:0]    dividend,
   input  logic [alcw_pkg::DVS_W-1:0]    divisor,
   output alcw_pkg::unit_status_type     status,
   output logic [alcw_pkg::DIV_W-1:0]    quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [alcw_pkg::DIV_STEP_W-1:0]   step_ff, step_in;
   logic [alcw_pkg::DIV_W-1:0]        quot_ff, quot_in;
   logic [alcw_pkg::DVS_W-1:0]        rem_ff, rem_in;
   logic [alcw_pkg::DVS_W-1:0]        dvs_ff, dvs_in;
   logic [alcw_pkg::DVS_W:0]          trial;
   logic                              qbit;

   // One restoring step: bring down the next dividend bit and try the divisor.
   always_comb begin
      trial   = {rem_ff, quot_ff[alcw_pkg::DIV_W-1]};
      qbit    = (trial >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (qbit) begin
            rem_in = alcw_pkg::DVS_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[alcw_pkg::DVS_W-1:0];
         end
         quot_in = {quot_ff[alcw_pkg::DIV_W-2:0], qbit};
         step_in = step_ff + 1'b1;
         if (step_ff == alcw_pkg::DIV_STEP_W'(alcw_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Quotient and remainder shift registers.
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quot_ff;

endmodule

@@ sv/averaged_load_cell_weight.sv @@
// Top level: sample accumulation, calibration sequencer, registers and result register.
//
// Input channel req_*: one converter sample with a read error flag per transfer.
// Samples are summed until samples_per_result of them (0 counts as 1) have been
// taken; a sample that does not end the batch leaves the sequencer idle, and the
// next may follow in the very next cycle.
// The sample that ends a batch starts the calibration: mean division, mean times
// reference, division by full scale, offset removal, times 1000, division by
// slope, clamp to min and max. Each division runs on the shared one-bit-per-cycle
// divider and each product on the serial multiplier, and no sample is taken until
// the result is loaded into the output register; a zero slope skips the last
// multiply, divide and clamp and gives a weight of zero.
// A flagged read error passes an all-zero result with status 1 through the finish
// state into the output register and clears the running sum and count.
// Result channel rsp_*: one output register. New samples are taken while a result
// waits; a newly finished result holds in the sequencer until the receiver takes
// the waiting one, and no sample is taken meanwhile.
// Configuration port csr_*: always ready, index 0 to 5, other indexes ignored.
// Reset (synchronous) restores the register defaults and clears sum, count and
// any result in flight.
`include "averaged_load_cell_weight_defines.svh"

module averaged_load_cell_weight (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [alcw_pkg::SAMPLE_BITS-1:0]       req_sample,
   input  logic                                   req_read_error,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [alcw_pkg::MEAN_BITS-1:0]         rsp_mean_raw,
   output logic [alcw_pkg::UV_BITS-1:0]           rsp_microvolts,
   output logic signed [alcw_pkg::GRAMS_BITS-1:0] rsp_grams,
   output logic                                   rsp_status,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [alcw_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [alcw_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DIV_MEAN = 3'd1;
   localparam logic [2:0] S_MUL_UV   = 3'd2;
   localparam logic [2:0] S_DIV_UV   = 3'd3;
   localparam logic [2:0] S_MUL_G    = 3'd4;
   localparam logic [2:0] S_DIV_G    = 3'd5;
   localparam logic [2:0] S_CLAMP    = 3'd6;
   localparam logic [2:0] S_FINISH   = 3'd7;

   // Configuration registers.
   logic [alcw_pkg::COUNT_BITS-1:0]         spr_ff;
   logic [alcw_pkg::REF_BITS-1:0]           ref_ff;
   logic signed [alcw_pkg::OFFSET_BITS-1:0] offset_ff;
   logic [alcw_pkg::SLOPE_BITS-1:0]         slope_ff;
   logic signed [alcw_pkg::GRAMS_BITS-1:0]  min_ff;
   logic signed [alcw_pkg::GRAMS_BITS-1:0]  max_ff;

   // Sequencer and accumulator.
   logic [2:0]                              state_ff, state_in;
   logic [alcw_pkg::SUM_BITS-1:0]           sum_ff, sum_in;
   logic [alcw_pkg::COUNT_BITS-1:0]         count_ff, count_in;

   // Working values of the result being computed.
   logic [alcw_pkg::SAMPLE_BITS-1:0]        mean_ff, mean_in;
   logic [alcw_pkg::UV_BITS-1:0]            uv_ff, uv_in;
   logic                                    neg_ff, neg_in;
   logic signed [alcw_pkg::GQ_W-1:0]        wide_ff, wide_in;
   logic signed [alcw_pkg::GRAMS_BITS-1:0]  grams_ff, grams_in;
   logic                                    status_ff, status_in;

   // Output register.
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [alcw_pkg::MEAN_BITS-1:0]          rsp_mean_ff;
   logic [alcw_pkg::UV_BITS-1:0]            rsp_uv_ff;
   logic signed [alcw_pkg::GRAMS_BITS-1:0]  rsp_grams_ff;
   logic                                    rsp_status_ff;
   logic                                    rsp_load;

   // Serial unit hookup.
   alcw_pkg::unit_status_type               div_stat, mul_stat;
   logic                                    div_start, mul_start;
   logic [alcw_pkg::DIV_W-1:0]              div_dividend, div_quot;
   logic [alcw_pkg::DVS_W-1:0]              div_divisor;
   logic [alcw_pkg::MUL_A_W-1:0]            mul_a;
   logic [alcw_pkg::MUL_B_W-1:0]            mul_b;
   logic [alcw_pkg::PROD_W-1:0]             mul_prod;

   // Helper values.
   logic                                    req_fire;
   logic [alcw_pkg::SUM_BITS-1:0]           sum_next;
   logic [alcw_pkg::COUNT_BITS:0]           taken, target;
   logic [alcw_pkg::REF_BITS-1:0]           ref_eff;
   logic [alcw_pkg::UV_BITS-1:0]            uv_q;
   logic signed [alcw_pkg::DIFF_W-1:0]      diff;
   logic [alcw_pkg::DIFF_W-1:0]             diff_mag;
   logic signed [alcw_pkg::GQ_W-1:0]        quot_pos, min_ext, max_ext, low_clamped;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Batch bookkeeping for the sample at the port.
   assign sum_next = sum_ff + alcw_pkg::SUM_BITS'(req_sample);
   assign taken    = {1'b0, count_ff} + 1'b1;
   assign target   = (spr_ff == '0) ? (alcw_pkg::COUNT_BITS + 1)'(1) : {1'b0, spr_ff};
   assign ref_eff  = (ref_ff == '0) ? alcw_pkg::REF_BITS'(alcw_pkg::DEFAULT_REF_UV) : ref_ff;

   // Offset removal and sign split ahead of the weight multiply.
   assign uv_q     = div_quot[alcw_pkg::UV_BITS-1:0];
   assign diff     = $signed({{(alcw_pkg::DIFF_W - alcw_pkg::UV_BITS){1'b0}}, uv_q})
                     - $signed({offset_ff[alcw_pkg::OFFSET_BITS-1], offset_ff});
   assign diff_mag = diff[alcw_pkg::DIFF_W-1] ? alcw_pkg::DIFF_W'(-diff) : diff;

   // Signed weight and its clamps.
   assign quot_pos    = $signed({1'b0, div_quot});
   assign min_ext     = alcw_pkg::GQ_W'(min_ff);
   assign max_ext     = alcw_pkg::GQ_W'(max_ff);
   assign low_clamped = (wide_ff < min_ext) ? min_ext : wide_ff;

   assign rsp_load = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);

   // Sequencer: accumulate, then step through the serial units.
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      mean_in      = mean_ff;
      uv_in        = uv_ff;
      neg_in       = neg_ff;
      wide_in      = wide_ff;
      grams_in     = grams_ff;
      status_in    = status_ff;
      div_start    = 1'b0;
      div_dividend = alcw_pkg::DIV_W'(sum_next);
      div_divisor  = alcw_pkg::DVS_W'(taken);
      mul_start    = 1'b0;
      mul_a        = alcw_pkg::MUL_A_W'(mean_ff);
      mul_b        = alcw_pkg::MUL_B_W'(ref_eff);
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_read_error) begin
                  sum_in    = '0;
                  count_in  = '0;
                  mean_in   = '0;
                  uv_in     = '0;
                  grams_in  = '0;
                  status_in = alcw_pkg::STATUS_READ_ERROR;
                  state_in  = S_FINISH;
               end else if (taken < target) begin
                  sum_in   = sum_next;
                  count_in = taken[alcw_pkg::COUNT_BITS-1:0];
               end else begin
                  sum_in    = '0;
                  count_in  = '0;
                  status_in = alcw_pkg::STATUS_OK;
                  div_start = 1'b1;
                  state_in  = S_DIV_MEAN;
               end
            end
         end
         S_DIV_MEAN: begin
            if (div_stat.done) begin
               if (div_quot > alcw_pkg::DIV_W'(alcw_pkg::FULL_SCALE)) begin
                  mean_in = alcw_pkg::SAMPLE_BITS'(alcw_pkg::FULL_SCALE);
               end else begin
                  mean_in = div_quot[alcw_pkg::SAMPLE_BITS-1:0];
               end
               // The multiplier takes the fresh mean at its start.
               mul_a     = alcw_pkg::MUL_A_W'(mean_in);
               mul_start = 1'b1;
               state_in  = S_MUL_UV;
            end
         end
         S_MUL_UV: begin
            div_dividend = mul_prod;
            div_divisor  = alcw_pkg::DVS_W'(alcw_pkg::FULL_SCALE);
            if (mul_stat.done) begin
               div_start = 1'b1;
               state_in  = S_DIV_UV;
            end
         end
         S_DIV_UV: begin
            mul_a = alcw_pkg::MUL_A_W'(alcw_pkg::GRAMS_SCALE);
            mul_b = alcw_pkg::MUL_B_W'(diff_mag);
            if (div_stat.done) begin
               uv_in  = uv_q;
               neg_in = diff[alcw_pkg::DIFF_W-1];
               if (slope_ff == '0) begin
                  grams_in = '0;
                  state_in = S_FINISH;
               end else begin
                  mul_start = 1'b1;
                  state_in  = S_MUL_G;
               end
            end
         end
         S_MUL_G: begin
            div_dividend = mul_prod;
            div_divisor  = alcw_pkg::DVS_W'(slope_ff);
            if (mul_stat.done) begin
               div_start = 1'b1;
               state_in  = S_DIV_G;
            end
         end
         S_DIV_G: begin
            if (div_stat.done) begin
               wide_in  = neg_ff ? -quot_pos : quot_pos;
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            if (low_clamped > max_ext) begin
               grams_in = max_ff;
            end else begin
               grams_in = low_clamped[alcw_pkg::GRAMS_BITS-1:0];
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // Output register handshake.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working values and the result payload.
   always_ff @(posedge clock) begin
      mean_ff   <= mean_in;
      uv_ff     <= uv_in;
      neg_ff    <= neg_in;
      wide_ff   <= wide_in;
      grams_ff  <= grams_in;
      status_ff <= status_in;
      if (rsp_load) begin
         rsp_mean_ff   <= alcw_pkg::MEAN_BITS'(mean_ff);
         rsp_uv_ff     <= uv_ff;
         rsp_grams_ff  <= grams_ff;
         rsp_status_ff <= status_ff;
      end
   end

   // Configuration registers, written on a csr transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         spr_ff    <= alcw_pkg::COUNT_BITS'(10);
         ref_ff    <= alcw_pkg::REF_BITS'(alcw_pkg::DEFAULT_REF_UV);
         offset_ff <= alcw_pkg::OFFSET_BITS'(74900);
         slope_ff  <= alcw_pkg::SLOPE_BITS'(400);
         min_ff    <= '0;
         max_ff    <= alcw_pkg::GRAMS_BITS'(6000);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            alcw_pkg::REG_SAMPLES_PER_RESULT:
               spr_ff <= csr_data[alcw_pkg::COUNT_BITS-1:0];
            alcw_pkg::REG_REFERENCE_UV:
               ref_ff <= csr_data[alcw_pkg::REF_BITS-1:0];
            alcw_pkg::REG_OFFSET_UV:
               offset_ff <= $signed(csr_data[alcw_pkg::OFFSET_BITS-1:0]);
            alcw_pkg::REG_SLOPE:
               slope_ff <= csr_data[alcw_pkg::SLOPE_BITS-1:0];
            alcw_pkg::REG_MIN_GRAMS:
               min_ff <= $signed(csr_data[alcw_pkg::GRAMS_BITS-1:0]);
            alcw_pkg::REG_MAX_GRAMS:
               max_ff <= $signed(csr_data[alcw_pkg::GRAMS_BITS-1:0]);
            default: begin
            end
         endcase
      end
   end

   // Shared serial divider.
   alcw_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_stat),
      .quotient (div_quot)
   );

   // Serial multiplier.
   alcw_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .status  (mul_stat),
      .product (mul_prod)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mean_raw   = rsp_mean_ff;
   assign rsp_microvolts = rsp_uv_ff;
   assign rsp_grams      = rsp_grams_ff;
   assign rsp_status     = rsp_status_ff;

   // The running sum and count are only touched while the sequencer is idle.
   `ALCW_ASSERT_IMP(a_batch_cleared, clock, reset, state_ff != S_IDLE,
                    (sum_ff == '0) && (count_ff == '0), "batch state not cleared")
   // An error result carries no reading.
   `ALCW_ASSERT_IMP(a_error_zero, clock, reset,
                    rsp_valid_ff && (rsp_status_ff == alcw_pkg::STATUS_READ_ERROR),
                    (rsp_mean_ff == '0) && (rsp_uv_ff == '0) && (rsp_grams_ff == '0),
                    "error result with nonzero fields")
   // The divider and multiplier never run at the same time.
   `ALCW_ASSERT_IMP(a_units_exclusive, clock, reset, div_stat.busy, !mul_stat.busy,
                    "divider and multiplier both busy")
   // A finished result reaches an empty output register in the next cycle.
   `ALCW_ASSERT_NEXT(a_finish_loads, clock, reset,
                     (state_ff == S_FINISH) && !rsp_valid_ff,
                     rsp_valid_ff && (state_ff == S_IDLE), "finished result not loaded")

endmodule
